// File: rtl/core/i2a_pkg.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// i2a_pkg
// Types, constants and helper functions of the integer to ASCII formatter.
// ----------------------------------------------------------------------------
package i2a_pkg;

    localparam int NumChars     = 11;  // sign plus ten decimal digits
    localparam int DecDigits    = 10;
    localparam int HexDigits    = 8;
    localparam int BitsPerStage = 4;
    localparam int NumDabStages = 32 / BitsPerStage;

    typedef enum logic [1:0] {
        KIND_SDEC = 2'd0,
        KIND_UDEC = 2'd1,
        KIND_HEXL = 2'd2,
        KIND_HEXU = 2'd3
    } kind_t;

    localparam logic [7:0] CHAR_ZERO    = 8'h30;
    localparam logic [7:0] CHAR_MINUS   = 8'h2d;
    localparam logic [7:0] CHAR_LOWER_A = 8'h61;
    localparam logic [7:0] CHAR_UPPER_A = 8'h41;
    localparam logic [7:0] CHAR_NONE    = 8'h00;

    typedef logic [7:0] char_t;
    typedef logic [3:0] cnt_t;

    // Binary to BCD conversion state
    typedef struct packed {
        kind_t       kind;
        logic        neg;
        logic [31:0] mag;
        logic [39:0] bcd;
        logic [31:0] sh;
    } dab_t;

    // Characters plus count; slot order depends on the stage
    typedef struct packed {
        char_t [NumChars-1:0] chars;
        cnt_t                 n;
    } fmt_t;

    // Run BitsPerStage shift-add-3 steps
    function automatic dab_t dabble_steps(input dab_t s);
        dab_t r;
        r = s;
        for (int st = 0; st < BitsPerStage; st++) begin
            for (int i = 0; i < DecDigits; i++) begin
                if (r.bcd[4*i +: 4] >= 4'd5) begin
                    r.bcd[4*i +: 4] = r.bcd[4*i +: 4] + 4'd3;
                end
            end
            {r.bcd, r.sh} = {r.bcd[38:0], r.sh, 1'b0};
        end
        return r;
    endfunction

    function automatic char_t digit_char(input logic [3:0] d, input logic upper);
        char_t c;
        if (d < 4'd10) begin
            c = CHAR_ZERO + {4'b0000, d};
        end
        else begin
            c = (upper ? CHAR_UPPER_A : CHAR_LOWER_A) + {4'b0000, d} - 8'd10;
        end
        return c;
    endfunction

endpackage

// File: rtl/core/integer_to_ascii_formatter.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// integer_to_ascii_formatter
// Formats a 32-bit word as signed/unsigned decimal or lower/upper hex ASCII.
// ----------------------------------------------------------------------------
// Input channel (in_valid / in_stall): one transfer carries kind and value.
// Output channel (out_valid / out_stall): one transfer carries one character,
// most significant first, with no leading zeros; last marks the final
// character of a number. Zero gives "0"; a negative signed word gives a
// leading '-' and its magnitude.
// Pipeline: the first character of a number passes one sign stage, eight
// binary-to-BCD stages of four bits each, a digit select stage, an align
// stage and the character shifter.
// Throughput: while out_stall is low the shifter sends one character a cycle;
// a number has 1 to 11 characters. The next number's first character follows
// the previous last one without a gap if the align stage holds it. Inputs
// keep entering one a cycle until the pipeline ahead of the shifter fills.
// Reset empties every stage and the shifter. While out_stall is high the
// current character holds, the stages fill up and then in_stall rises.
// ----------------------------------------------------------------------------
module integer_to_ascii_formatter (
    input  logic        clk,
    input  logic        rst_n,
    input  logic        in_valid,
    output logic        in_stall,
    input  logic [1:0]  kind,
    input  logic [31:0] value,
    output logic        out_valid,
    input  logic        out_stall,
    output logic [7:0]  char_code,
    output logic        last
);
    import i2a_pkg::*;

    // Conversion stages 0..NumDabStages
    dab_t dab_reg   [NumDabStages+1];
    logic dab_v_reg [NumDabStages+1];
    logic dab_rdy   [NumDabStages+1];
    dab_t dab0_next;

    fmt_t sel_reg, sel_next;
    logic sel_v_reg, sel_rdy;
    fmt_t aln_reg, aln_next;
    logic aln_v_reg, aln_rdy;

    char_t [NumChars-1:0] ser_chars_reg, ser_chars_next;
    cnt_t                 ser_left_reg, ser_left_next;
    logic                 ser_rdy;
    logic                 out_xfer;

    logic [3:0] dg [DecDigits];
    cnt_t       nd;
    cnt_t       idx;

    // Handshake and ready chain
    assign out_valid = (ser_left_reg != cnt_t'(0));
    assign last      = (ser_left_reg == cnt_t'(1));
    assign char_code = ser_chars_reg[0];
    assign out_xfer  = out_valid && !out_stall;
    assign ser_rdy   = !out_valid || (out_xfer && last);
    assign aln_rdy   = !aln_v_reg || ser_rdy;
    assign sel_rdy   = !sel_v_reg || aln_rdy;

    always_comb
    begin
        dab_rdy[NumDabStages] = !dab_v_reg[NumDabStages] || sel_rdy;
        for (int k = NumDabStages - 1; k >= 0; k--) begin
            dab_rdy[k] = !dab_v_reg[k] || dab_rdy[k+1];
        end
    end

    assign in_stall = !dab_rdy[0];

    // Sign stage input
    always_comb
    begin
        dab0_next.kind = kind_t'(kind);
        dab0_next.neg  = (kind_t'(kind) == KIND_SDEC) && value[31];
        dab0_next.mag  = dab0_next.neg ? (32'd0 - value) : value;
        dab0_next.bcd  = '0;
        dab0_next.sh   = dab0_next.mag;
    end

    // Digit select: pick digits, count them, place the sign
    always_comb
    begin
        for (int i = 0; i < DecDigits; i++) begin
            if (!dab_reg[NumDabStages].kind[1]) begin
                dg[i] = dab_reg[NumDabStages].bcd[4*i +: 4];
            end
            else if (i < HexDigits) begin
                dg[i] = dab_reg[NumDabStages].mag[4*i +: 4];
            end
            else begin
                dg[i] = 4'd0;
            end
        end
        nd = cnt_t'(1);
        for (int i = 1; i < DecDigits; i++) begin
            if (dg[i] != 4'd0) begin
                nd = cnt_t'(i + 1);
            end
        end
        for (int j = 0; j < NumChars; j++) begin
            sel_next.chars[j] = CHAR_NONE;
            if (j < DecDigits) begin
                if (cnt_t'(j) < nd) begin
                    sel_next.chars[j] = digit_char(dg[j],
                        dab_reg[NumDabStages].kind == KIND_HEXU);
                end
            end
            if (dab_reg[NumDabStages].neg && (cnt_t'(j) == nd)) begin
                sel_next.chars[j] = CHAR_MINUS;
            end
        end
        sel_next.n = nd + cnt_t'(dab_reg[NumDabStages].neg);
    end

    // Align: reorder so slot 0 holds the most significant character
    always_comb
    begin
        aln_next.n = sel_reg.n;
        for (int k = 0; k < NumChars; k++) begin
            aln_next.chars[k] = CHAR_NONE;
            idx = sel_reg.n - cnt_t'(1) - cnt_t'(k);
            for (int j = 0; j < NumChars; j++) begin
                if ((cnt_t'(k) < sel_reg.n) && (idx == cnt_t'(j))) begin
                    aln_next.chars[k] = sel_reg.chars[j];
                end
            end
        end
    end

    // Character shifter
    always_comb
    begin
        ser_chars_next = ser_chars_reg;
        ser_left_next  = ser_left_reg;
        if (ser_rdy) begin
            ser_chars_next = aln_reg.chars;
            ser_left_next  = aln_v_reg ? aln_reg.n : cnt_t'(0);
        end
        else if (out_xfer) begin
            ser_chars_next = {CHAR_NONE, ser_chars_reg[NumChars-1:1]};
            ser_left_next  = ser_left_reg - cnt_t'(1);
        end
    end

    // Valid bits
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n) begin
            for (int k = 0; k <= NumDabStages; k++) begin
                dab_v_reg[k] <= 1'b0;
            end
            sel_v_reg    <= 1'b0;
            aln_v_reg    <= 1'b0;
            ser_left_reg <= '0;
        end
        else begin
            if (dab_rdy[0]) begin
                dab_v_reg[0] <= in_valid;
            end
            for (int k = 1; k <= NumDabStages; k++) begin
                if (dab_rdy[k]) begin
                    dab_v_reg[k] <= dab_v_reg[k-1];
                end
            end
            if (sel_rdy) begin
                sel_v_reg <= dab_v_reg[NumDabStages];
            end
            if (aln_rdy) begin
                aln_v_reg <= sel_v_reg;
            end
            ser_left_reg <= ser_left_next;
        end
    end

    // Payload
    always_ff @(posedge clk)
    begin
        if (dab_rdy[0]) begin
            dab_reg[0] <= dab0_next;
        end
        for (int k = 1; k <= NumDabStages; k++) begin
            if (dab_rdy[k]) begin
                dab_reg[k] <= dabble_steps(dab_reg[k-1]);
            end
        end
        if (sel_rdy) begin
            sel_reg <= sel_next;
        end
        if (aln_rdy) begin
            aln_reg <= aln_next;
        end
        ser_chars_reg <= ser_chars_next;
    end

    // Checks
    a_cont_number : assert property (@(posedge clk) disable iff (!rst_n)
        out_xfer && !last |=> out_valid)
        else $error("number cut short before its last character");

    a_align_hold : assert property (@(posedge clk) disable iff (!rst_n)
        aln_v_reg && !ser_rdy |=> aln_v_reg && $stable(aln_reg))
        else $error("aligned number lost while the shifter is busy");

    a_count_range : assert property (@(posedge clk) disable iff (!rst_n)
        aln_v_reg |-> (aln_reg.n != cnt_t'(0)) && (aln_reg.n <= cnt_t'(NumChars)))
        else $error("character count out of range");

    a_stall_full : assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> dab_v_reg[0] && out_valid)
        else $error("input stalled with room in the pipeline");

endmodule

// File: bench/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the integer to ASCII formatter. A table of directed
// numbers covers zero in every format, extremes and the sign corner; random
// numbers follow in three idle/stall phases. Each accepted number is turned
// into its expected character stream, and every character transfer on the
// output is checked for code and last flag, in order.
// ----------------------------------------------------------------------------
module testbench;

    import i2a_pkg::*;

    localparam int  DirectedRows = 21;
    localparam int  RandomPerPhase = 170;
    localparam int  TailCycles   = 40;
    localparam int  CycleLimit   = 200000;

    typedef struct {
        kind_t       kind;
        logic [31:0] value;
        string       text;   // empty: take the expected characters from the predictor
    } number_row_t;

    typedef struct {
        char_t code;
        logic  last;
    } char_item_t;

    logic        clk;
    logic        rst_n     = 1'b0;
    logic        in_valid  = 1'b0;
    logic        in_stall;
    kind_t       kind      = KIND_SDEC;
    logic [31:0] value     = 32'h0;
    logic        out_valid;
    logic        out_stall = 1'b0;
    char_t       char_code;
    logic        last;

    char_item_t  expected_chars[$];
    int          mismatches    = 0;
    int          cycles        = 0;
    int          send_idle_pct = 0;
    int          stall_pct     = 0;

    number_row_t directed_rows [DirectedRows] = '{
        '{KIND_SDEC, 32'h0000_0000, "0"},
        '{KIND_UDEC, 32'h0000_0000, "0"},
        '{KIND_HEXL, 32'h0000_0000, "0"},
        '{KIND_HEXU, 32'h0000_0000, "0"},
        '{KIND_SDEC, 32'h8000_0000, "-2147483648"},
        '{KIND_SDEC, 32'h7FFF_FFFF, "2147483647"},
        '{KIND_SDEC, 32'hFFFF_FFFF, "-1"},
        '{KIND_SDEC, 32'h0000_0001, "1"},
        '{KIND_UDEC, 32'hFFFF_FFFF, "4294967295"},
        '{KIND_UDEC, 32'h8000_0000, "2147483648"},
        '{KIND_UDEC, 32'h0000_0001, "1"},
        '{KIND_UDEC, 32'd1000000000, "1000000000"},
        '{KIND_HEXL, 32'hFFFF_FFFF, "ffffffff"},
        '{KIND_HEXU, 32'hFFFF_FFFF, "FFFFFFFF"},
        '{KIND_HEXL, 32'hDEAD_BEEF, "deadbeef"},
        '{KIND_HEXU, 32'h0ABC_DEF0, "ABCDEF0"},
        '{KIND_HEXL, 32'h0000_0010, "10"},
        '{KIND_SDEC, 32'hFFFF_FF9C, "-100"},
        '{KIND_SDEC, 32'h1234_5678, ""},
        '{KIND_UDEC, 32'h7654_3210, ""},
        '{KIND_HEXU, 32'h0000_A5F0, ""}
    };

    integer_to_ascii_formatter DUT (
        .clk       (clk),
        .rst_n     (rst_n),
        .in_valid  (in_valid),
        .in_stall  (in_stall),
        .kind      (kind),
        .value     (value),
        .out_valid (out_valid),
        .out_stall (out_stall),
        .char_code (char_code),
        .last      (last)
    );

    initial
    begin
        clk = 1'b0;
        forever #5 clk = ~clk;
    end

    // Character stream of one number, most significant first
    function automatic void queue_formatted(kind_t k, logic [31:0] word);
        string       digit_set;
        char_t       chars[$];
        logic [31:0] mag;
        logic        neg;
        neg = (k == KIND_SDEC) && word[31];
        mag = neg ? (32'h0 - word) : word;
        digit_set = (k == KIND_HEXU) ? "0123456789ABCDEF" : "0123456789abcdef";
        if (mag == 32'h0)
        begin
            chars.push_front(CHAR_ZERO);
        end
        else if (k == KIND_HEXL || k == KIND_HEXU)
        begin
            while (mag != 32'h0)
            begin
                chars.push_front(digit_set[mag[3:0]]);
                mag = mag >> 4;
            end
        end
        else
        begin
            while (mag != 32'h0)
            begin
                chars.push_front(digit_set[mag % 10]);
                mag = mag / 10;
            end
        end
        if (neg)
        begin
            chars.push_front(CHAR_MINUS);
        end
        foreach (chars[i])
        begin
            expected_chars.push_back('{chars[i], i == chars.size() - 1});
        end
    endfunction

    function automatic void queue_text(string text);
        for (int i = 0; i < text.len(); i++)
        begin
            expected_chars.push_back('{char_t'(text[i]), i == text.len() - 1});
        end
    endfunction

    // Mix of full-range words, short numbers and digit-count boundaries
    function automatic logic [31:0] random_word();
        logic [31:0] p;
        p = 32'd1;
        case ($urandom_range(7))
            0: return $urandom_range(99);
            1:
            begin
                repeat ($urandom_range(9)) p = p * 10;
                return p + $urandom_range(2) - 1;
            end
            2: return (32'd1 << (4 * $urandom_range(7))) - $urandom_range(1);
            3: return 32'h0 - $urandom_range(1, 1000);
            4:
            begin
                case ($urandom_range(4))
                    0: return 32'h0;
                    1: return 32'h7FFF_FFFF;
                    2: return 32'h8000_0000;
                    3: return 32'h8000_0001;
                    default: return 32'hFFFF_FFFF;
                endcase
            end
            5: return $urandom >> $urandom_range(31);
            default: return $urandom;
        endcase
    endfunction

    // Present one number and hold it until the transfer; valid stays high afterwards
    task automatic send_number(kind_t k, logic [31:0] v, string text);
        while ($urandom_range(99) < send_idle_pct)
        begin
            in_valid <= 1'b0;
            @(posedge clk);
        end
        in_valid <= 1'b1;
        kind     <= k;
        value    <= v;
        @(posedge clk);
        while (in_stall)
        begin
            @(posedge clk);
        end
        if (text.len() != 0)
        begin
            queue_text(text);
        end
        else
        begin
            queue_formatted(k, v);
        end
    endtask

    task automatic hold_until_drained();
        in_valid <= 1'b0;
        @(posedge clk);
        while (expected_chars.size() != 0)
        begin
            @(posedge clk);
        end
    endtask

    task automatic send_random(int count);
        for (int n = 0; n < count; n++)
        begin
            send_number(kind_t'($urandom_range(3)), random_word(), "");
        end
    endtask

    // Check each character transfer, then pick the next stall
    always @(posedge clk)
    begin
        char_item_t want;
        if (rst_n && out_valid && !out_stall)
        begin
            if (expected_chars.size() == 0)
            begin
                mismatches++;
                if (mismatches <= 10)
                begin
                    $display("unexpected char: code %h last %b", char_code, last);
                end
            end
            else
            begin
                want = expected_chars.pop_front();
                if (char_code !== want.code || last !== want.last)
                begin
                    mismatches++;
                    if (mismatches <= 10)
                    begin
                        $display("char mismatch: code exp %h got %h, last exp %b got %b",
                                 want.code, char_code, want.last, last);
                    end
                end
            end
        end
        out_stall <= ($urandom_range(99) < stall_pct);
    end

    always @(posedge clk)
    begin
        cycles++;
        if (cycles > CycleLimit)
        begin
            $display("testbench: done, errors");
            $finish;
        end
    end

    initial
    begin
        send_idle_pct = 30;
        stall_pct     = 58;
        repeat (2) @(posedge clk);
        rst_n <= 1'b1;
        @(posedge clk);

        foreach (directed_rows[i])
        begin
            send_number(directed_rows[i].kind, directed_rows[i].value,
                        directed_rows[i].text);
        end
        send_random(RandomPerPhase);
        hold_until_drained();

        send_idle_pct = 58;
        stall_pct     = 30;
        send_random(RandomPerPhase);
        hold_until_drained();

        send_idle_pct = 0;
        stall_pct     = 0;
        send_random(RandomPerPhase);
        hold_until_drained();

        repeat (TailCycles) @(posedge clk);
        if (mismatches == 0 && expected_chars.size() == 0)
        begin
            $display("testbench: done, clean");
        end
        else
        begin
            $display("testbench: done, errors");
        end
        $finish;
    end

endmodule
